// File: hw/rtl/jls_pkg.sv
`default_nettype none

package jls_pkg;

  // Q16.16 representation of 1.0, the starting guess of every unknown.
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // Input actions.
  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  // Register select, taken from paddr bit 2.
  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_TOL  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_WRITE,
    S_CHECK,
    S_OUT,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/jacobi_linear_solver_unit.sv
`default_nettype none

// Jacobi linear solver. Load transactions (action 0 for a matrix element at
// row and column, action 1 for a right-hand-side element at row) are taken
// while busy is low and may then follow one another on every clock. A start
// transaction (action 2) runs Jacobi sweeps from an all-ones guess on the
// first n unknowns, n being the size register clamped to 1..MAX_SIZE, and
// then presents one result per unknown, index ascending, each for exactly
// one cycle under out_strobe; the receiver cannot stall, so it must take
// every result as it appears. busy stays high from the start transaction
// until the last result has been shown. For each unknown of a sweep the
// column is streamed through the single multiply-accumulate unit, its
// pipeline drains, the bit-serial divider is launched and waited for, and
// the new value is written back. A zero pivot skips the divider. Every sweep
// ends with a convergence check. busy stays high while the results are
// presented, the last of them in the cycle before busy falls.
// Store entries that were never loaded read back as unspecified data.
module jacobi_linear_solver_unit #(
  parameter int MAX_SIZE = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  // Configuration port.
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [2:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Command channel.
  input  wire               start,
  output logic              busy,
  input  wire [1:0]         in_action,
  input  wire [3:0]         in_row,
  input  wire [3:0]         in_col,
  input  wire signed [31:0] in_value,
  // Result channel.
  output logic              out_strobe,
  output logic [3:0]        out_index,
  output logic signed [31:0] out_solution,
  output logic [4:0]        out_iterations,
  output logic              out_converged,
  output logic              out_zero_pivot,
  output logic              out_last
);

  import jls_pkg::*;

  localparam int IW = $clog2(MAX_SIZE);
  localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
  // Counters must reach the clamped size, which never exceeds 31.
  localparam int CW = (IW > 5) ? IW : 5;

  // Configuration registers.
  logic [4:0]  size_r;
  logic [30:0] tol_r;

  // Sequencer state.
  state_t      state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, n_r, n_nxt;
  logic [4:0]  iter_r, iter_nxt;
  logic        first_r, first_nxt;
  logic        rb_r, rb_nxt;
  logic        drain_r, drain_nxt;
  logic        conv_r, conv_nxt;
  logic        zp_r, zp_nxt;
  logic [32:0] absmax_r, absmax_nxt;
  logic [35:0] thr_r, thr_nxt;

  // Multiply-accumulate pipeline.
  logic        s1_v_r, s1_diag_r, s2_v_r;
  logic signed [63:0] p_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] d_r, xi_r;

  // Memory ports.
  logic signed [31:0] a_q, g_q, b_q;
  logic [AW-1:0] a_waddr, a_raddr;
  logic          a_we, b_we, g_we;
  logic [IW:0]   g_waddr, g_raddr;
  logic signed [31:0] g_wdata;

  // Controls.
  logic       accept;
  logic       mac_issue, out_issue;
  logic       div_start, div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] gval;
  logic signed [31:0] res;
  logic signed [63:0] num;
  logic signed [65:0] num_wide;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_sat;
  logic signed [32:0] diff;
  logic [32:0] diff_abs;
  logic [CW-1:0] n_start;
  logic [CW-1:0] iter_ext;

  assign accept = start && !busy;
  assign pready = 1'b1;

  // Configuration writes complete on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 5'd16;
      tol_r  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SIZE: size_r <= pwdata[4:0];
        REG_TOL:  tol_r  <= pwdata[30:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SIZE: prdata = {27'd0, size_r};
      REG_TOL:  prdata = {1'b0, tol_r};
      default:  prdata = '0;
    endcase
  end

  // The matrix is kept at row * MAX_SIZE + column, so a column walk steps
  // by MAX_SIZE; loads whose indexes fall outside the store are dropped.
  assign a_we = accept && (in_action == ACT_LOAD_A)
              && (int'(in_row) < MAX_SIZE) && (int'(in_col) < MAX_SIZE);
  assign a_waddr = AW'(int'(in_row) * MAX_SIZE + int'(in_col));
  assign a_raddr = AW'(int'(j_r) * MAX_SIZE + int'(i_r));
  assign b_we = accept && (in_action == ACT_LOAD_B) && (int'(in_row) < MAX_SIZE);

  jls_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_mat (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (in_value),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  jls_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_rhs (
    .clk   (clk),
    .we    (b_we),
    .waddr (IW'(in_row)),
    .wdata (in_value),
    .raddr (i_r[IW-1:0]),
    .rdata (b_q)
  );

  // Two banks of guesses: a sweep reads bank rb_r and writes the other one,
  // and the bank pointer flips at the end of each sweep. The first sweep
  // ignores the stored bank and uses 1.0 throughout. Each bank spans a full
  // power of two so that the bank bit can sit on top of the index.
  assign g_we    = (state_r == S_WRITE);
  assign g_waddr = {~rb_r, i_r[IW-1:0]};
  assign g_wdata = res;
  assign g_raddr = out_issue ? {rb_r, k_r[IW-1:0]} : {rb_r, j_r[IW-1:0]};

  jls_ram #(.WIDTH(32), .DEPTH(2 << IW)) u_guess (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_q)
  );

  assign gval = first_r ? Q_ONE : g_q;

  // Numerator b * 2^16 - sum, saturated to 64 bits.
  always_comb begin
    num_wide = 66'(signed'({b_q, 16'd0})) - 66'(acc_r);
    if (num_wide > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
      num = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (num_wide < -66'sh0_8000_0000_0000_0000) begin
      num = 64'sh8000_0000_0000_0000;
    end else begin
      num = num_wide[63:0];
    end
  end

  // Saturating accumulation of the registered product.
  always_comb begin
    acc_sum = 65'(acc_r) + 65'(p_r);
    if (acc_sum[64] != acc_sum[63]) begin
      acc_sat = acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      acc_sat = acc_sum[63:0];
    end
  end

  jls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // A zero pivot keeps the current value of the unknown.
  assign res      = (d_r == 32'sd0) ? xi_r : div_q;
  assign diff     = 33'(xi_r) - 33'(res);
  assign diff_abs = diff[32] ? (33'd0 - diff) : diff;
  assign iter_ext = CW'(iter_r);

  always_comb begin
    if (size_r == 5'd0) begin
      n_start = CW'(1);
    end else if (int'(size_r) > MAX_SIZE) begin
      n_start = CW'(MAX_SIZE);
    end else begin
      n_start = CW'(size_r);
    end
  end

  // Next-state and counter logic.
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    iter_nxt   = iter_r;
    first_nxt  = first_r;
    rb_nxt     = rb_r;
    drain_nxt  = drain_r;
    conv_nxt   = conv_r;
    zp_nxt     = zp_r;
    absmax_nxt = absmax_r;
    thr_nxt    = thr_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_action == ACT_START)) begin
          state_nxt  = S_MAC;
          n_nxt      = n_start;
          thr_nxt    = 36'(tol_r) * 36'(n_start);
          i_nxt      = '0;
          j_nxt      = '0;
          iter_nxt   = '0;
          first_nxt  = 1'b1;
          conv_nxt   = 1'b0;
          zp_nxt     = 1'b0;
          absmax_nxt = '0;
        end
      end
      S_MAC: begin
        if (j_r == n_r - CW'(1)) begin
          j_nxt     = '0;
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        if (d_r == 32'sd0) begin
          zp_nxt    = 1'b1;
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (diff_abs > absmax_r) begin
          absmax_nxt = diff_abs;
        end
        if (i_r == n_r - CW'(1)) begin
          i_nxt     = '0;
          state_nxt = S_CHECK;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_MAC;
        end
      end
      S_CHECK: begin
        iter_nxt = iter_r + 5'd1;
        rb_nxt   = ~rb_r;
        if ({3'd0, absmax_r} <= thr_r) begin
          conv_nxt  = 1'b1;
          k_nxt     = '0;
          state_nxt = S_OUT;
        end else if (iter_ext + CW'(1) >= n_r) begin
          k_nxt     = '0;
          state_nxt = S_OUT;
        end else begin
          first_nxt  = 1'b0;
          absmax_nxt = '0;
          state_nxt  = S_MAC;
        end
      end
      S_OUT: begin
        if (k_r == n_r - CW'(1)) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    busy      = 1'b1;
    mac_issue = 1'b0;
    out_issue = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE:   busy = 1'b0;
      S_MAC:    mac_issue = 1'b1;
      S_DIV_GO: div_start = (d_r != 32'sd0);
      S_OUT:    out_issue = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_strobe <= 1'b0;
      iter_r     <= '0;
      first_r    <= 1'b1;
      rb_r       <= 1'b0;
      conv_r     <= 1'b0;
      zp_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_v_r     <= mac_issue;
      s2_v_r     <= s1_v_r && !s1_diag_r;
      out_strobe <= out_issue;
      iter_r     <= iter_nxt;
      first_r    <= first_nxt;
      rb_r       <= rb_nxt;
      conv_r     <= conv_nxt;
      zp_r       <= zp_nxt;
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
    drain_r   <= drain_nxt;
    absmax_r  <= absmax_nxt;
    thr_r     <= thr_nxt;
    s1_diag_r <= (j_r == i_r);
    // The diagonal element is captured together with the current value of
    // the unknown, which a zero pivot passes through unchanged.
    if (s1_v_r && s1_diag_r) begin
      d_r  <= a_q;
      xi_r <= gval;
    end
    p_r <= 64'(a_q) * 64'(gval);
    if ((state_r == S_IDLE) || (state_r == S_WRITE)) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_sat;
    end
    out_index      <= k_r[3:0];
    out_last       <= (k_r == n_r - CW'(1));
  end

  assign out_solution   = g_q;
  assign out_iterations = iter_r;
  assign out_converged  = conv_r;
  assign out_zero_pivot = zp_r;

  a_strobe_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result shown while idle");
  a_last_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_last && out_strobe |=> !out_strobe) else $error("result after last");
  a_iter_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_iterations != 5'd0) else $error("result with no sweep");
  a_div_only_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT) else $error("stray divider result");

endmodule

`default_nettype wire

// File: hw/rtl/jls_ram.sv
`default_nettype none

module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/jls_div.sv
`default_nettype none

module jls_div (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire signed [63:0] num,
  input  wire signed [31:0] den,
  output logic              done,
  output logic signed [31:0] quo
);

  import jls_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] md_r;
  logic        neg_r;
  logic        done_r, done_nxt;
  logic signed [31:0] quo_r, quo_nxt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        qbit;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    rem_sh   = {rem_r, dvd_r[63]};
    rem_sub  = rem_sh - {1'b0, md_r};
    qbit     = (rem_sh >= {1'b0, md_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = num[63] ? (64'd0 - num) : num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[62:0], qbit};
      rem_nxt = qbit ? rem_sub[31:0] : rem_sh[31:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (neg_r) begin
          quo_nxt = (dvd_nxt >= 64'h8000_0000) ? 32'sh8000_0000
                                                : (32'sd0 - $signed(dvd_nxt[31:0]));
        end else begin
          quo_nxt = (dvd_nxt > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                               : $signed(dvd_nxt[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      md_r  <= den[31] ? (32'd0 - den) : den;
      neg_r <= num[63] ^ den[31];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_ends : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");
  a_done_once : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held longer than a cycle");

endmodule

`default_nettype wire

// File: tb/tb_jacobi_linear_solver_unit.sv
`default_nettype none

// Self-checking bench for the Jacobi solver. Every accepted start transaction
// without a typed result is replayed on a behavioural Jacobi solver kept in the
// bench, which works on its own copies of the matrix store, the right-hand-side
// store and the two configuration registers. Each start transaction queues one
// expected solution record per unknown. The result monitor then compares every
// strobed record, field by field, against the oldest record in that queue.
module tb_jacobi_linear_solver_unit;
  import jls_pkg::*;

  localparam int           DIM         = 16;
  localparam logic [1:0]   ACT_IGNORED = 2'd3;
  localparam logic [30:0]  TOL_MAX     = 31'h7FFF_FFFF;
  localparam longint       SUM_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint       SUM_MIN     = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
  localparam int           CYCLE_LIMIT = 4_000_000;
  localparam int           RANDOM_ITEMS = 120;

  typedef struct packed {
    logic [3:0]        index;
    logic signed [31:0] solution;
    logic [4:0]        iterations;
    logic              converged;
    logic              zero_pivot;
    logic              last;
  } solution_rec_t;

  // One row of the directed table. Where known is set, the expected single
  // solution record is typed into the row rather than taken from the solver.
  typedef struct packed {
    logic [4:0]         size;
    logic [30:0]        tol;
    logic [1:0]         action;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic               known;
    logic signed [31:0] k_solution;
    logic [4:0]         k_iterations;
    logic               k_converged;
    logic               k_zero_pivot;
  } directed_row_t;

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic start, busy;
  logic [1:0] in_action;
  logic [3:0] in_row, in_col;
  logic signed [31:0] in_value;
  logic out_strobe;
  logic [3:0] out_index;
  logic signed [31:0] out_solution;
  logic [4:0] out_iterations;
  logic out_converged, out_zero_pivot, out_last;

  jacobi_linear_solver_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .in_action(in_action), .in_row(in_row), .in_col(in_col), .in_value(in_value),
    .out_strobe(out_strobe), .out_index(out_index), .out_solution(out_solution),
    .out_iterations(out_iterations), .out_converged(out_converged),
    .out_zero_pivot(out_zero_pivot), .out_last(out_last)
  );

  // Shadow of the block's stores and registers.
  logic signed [31:0] coeff_mem [DIM][DIM];
  logic signed [31:0] rhs_mem [DIM];
  logic [4:0]         size_reg;
  logic [30:0]        tol_reg;

  solution_rec_t pending_solutions[$];
  int mismatches, solves_seen, records_seen, items_sent, cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a solver that never finishes ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("jacobi_linear_solver_unit verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h (record %0d)", what, got, want, records_seen);
    mismatches++;
  endtask

  // Saturating 64-bit add, as the accumulator of the block behaves.
  function automatic longint sum_sat(input longint a, input longint b);
    longint r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SUM_MIN : SUM_MAX;
    return r;
  endfunction

  // Truncating division of a Q32.32 numerator by a Q16.16 pivot, saturated.
  function automatic logic signed [31:0] quot_sat(input longint num, input longint den);
    logic [63:0] mn, md, q;
    logic neg;
    neg = (num < 0) != (den < 0);
    mn = (num < 0) ? 64'd0 - 64'(num) : 64'(num);
    md = (den < 0) ? 64'd0 - 64'(den) : 64'(den);
    q = mn / md;
    if (neg) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - q);
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
  endfunction

  // Runs the Jacobi sweeps for the current size and tolerance and queues one
  // solution record per unknown.
  task automatic jacobi_predict();
    logic signed [31:0] guess [DIM];
    logic signed [31:0] fresh [DIM];
    longint acc, num, diff, absmax;
    int n, sweeps;
    logic conv, zp;
    solution_rec_t rec;
    n = (size_reg < 1) ? 1 : ((size_reg > DIM) ? DIM : int'(size_reg));
    for (int i = 0; i < DIM; i++) guess[i] = Q_ONE;
    sweeps = 0;
    conv = 1'b0;
    zp = 1'b0;
    forever begin
      sweeps++;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++)
          if (j != i) acc = sum_sat(acc, longint'(coeff_mem[j][i]) * longint'(guess[j]));
        if (coeff_mem[i][i] == 0) begin
          zp = 1'b1;
          fresh[i] = guess[i];
        end else begin
          if (acc == SUM_MIN)
            num = sum_sat(sum_sat(longint'(rhs_mem[i]) * 65536, SUM_MAX), 1);
          else
            num = sum_sat(longint'(rhs_mem[i]) * 65536, -acc);
          fresh[i] = quot_sat(num, longint'(coeff_mem[i][i]));
        end
      end
      absmax = 0;
      for (int i = 0; i < n; i++) begin
        diff = longint'(guess[i]) - longint'(fresh[i]);
        if (diff < 0) diff = -diff;
        if (diff > absmax) absmax = diff;
      end
      if (absmax <= longint'(tol_reg) * n) begin
        conv = 1'b1;
        break;
      end
      if (sweeps >= n) break;
      for (int i = 0; i < n; i++) guess[i] = fresh[i];
    end
    for (int i = 0; i < n; i++) begin
      rec.index = 4'(i);
      rec.solution = fresh[i];
      rec.iterations = 5'(sweeps);
      rec.converged = conv;
      rec.zero_pivot = zp;
      rec.last = (i == n - 1);
      pending_solutions.push_back(rec);
    end
  endtask

  // Presents one command transaction and holds it until the block takes it.
  // start is left high; the caller lowers it only when a gap follows.
  task automatic send_command(input logic [1:0] act, input logic [3:0] r,
                              input logic [3:0] c, input logic signed [31:0] v,
                              input bit predict);
    start <= 1'b1;
    in_action <= act;
    in_row <= r;
    in_col <= c;
    in_value <= v;
    do @(posedge clk); while (busy);
    items_sent++;
    case (act)
      ACT_LOAD_A: coeff_mem[r][c] = v;
      ACT_LOAD_B: rhs_mem[r] = v;
      ACT_START: begin
        solves_seen++;
        if (predict) jacobi_predict();
      end
      default: ;
    endcase
  endtask

  // Mostly back-to-back transactions, some short gaps and the odd long one.
  task automatic command_gap();
    int pick, len;
    pick = $urandom_range(0, 9);
    len = (pick < 6) ? 0 : ((pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Waits until every solution record has come out and the block is idle, then
  // lets the result stage settle before the registers are touched.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_solutions.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_SIZE) size_reg = data[4:0];
    else tol_reg = data[30:0];
  endtask

  task automatic configure(input logic [4:0] sz, input logic [30:0] tol);
    wait_idle();
    write_reg(REG_SIZE, 32'(sz));
    write_reg(REG_TOL, 32'(tol));
  endtask

  // Result monitor: the receiver cannot stall, so every strobe is a record.
  always @(posedge clk) begin
    solution_rec_t want;
    if (rst_n && out_strobe) begin
      records_seen++;
      if (pending_solutions.size() == 0) begin
        report_mismatch("unexpected record, index", out_index, 0);
      end else begin
        want = pending_solutions.pop_front();
        if (out_index !== want.index) report_mismatch("index", out_index, want.index);
        if (out_solution !== want.solution)
          report_mismatch("solution", out_solution, want.solution);
        if (out_iterations !== want.iterations)
          report_mismatch("iterations", out_iterations, want.iterations);
        if (out_converged !== want.converged)
          report_mismatch("converged", out_converged, want.converged);
        if (out_zero_pivot !== want.zero_pivot)
          report_mismatch("zero_pivot", out_zero_pivot, want.zero_pivot);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  directed_row_t directed_tab [20];

  initial begin
    solution_rec_t typed_rec;
    int random_count, burst, pick, n;
    logic [4:0] sz;
    logic [30:0] tol;
    logic [3:0] r, c;
    logic signed [31:0] v;

    // Size-one rows with typed results: a plain solve, a zero pivot, a tiny
    // pivot saturating either way. Then the most negative pivot, an ignored
    // action, size zero, a two-by-two system and the full size with the size
    // register saturated.
    directed_tab = '{
      '{5'd1, TOL_MAX, ACT_LOAD_A, 4'd0, 4'd0, Q_ONE, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, TOL_MAX, ACT_LOAD_B, 4'd0, 4'd0, 32'sh0002_0000, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, TOL_MAX, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b1, 32'sh0002_0000, 5'd1, 1'b1, 1'b0},
      '{5'd1, 31'd0, ACT_LOAD_A, 4'd0, 4'd0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b1, Q_ONE, 5'd1, 1'b1, 1'b1},
      '{5'd1, 31'd0, ACT_LOAD_A, 4'd0, 4'd0, 32'sd1, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_LOAD_B, 4'd0, 4'd0, 32'sh7FFF_FFFF, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b1, 32'sh7FFF_FFFF, 5'd1, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_LOAD_B, 4'd0, 4'd0, 32'sh8000_0000, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b1, 32'sh8000_0000, 5'd1, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_LOAD_A, 4'd0, 4'd0, 32'sh8000_0000, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_IGNORED, 4'd15, 4'd15, -32'sd1, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd1, 31'd0, ACT_LOAD_A, 4'd0, 4'd0, Q_ONE, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd0, 31'd0, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd2, 31'd0, ACT_LOAD_A, 4'd1, 4'd0, 32'sh8000_0000, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd2, 31'd0, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd16, TOL_MAX, ACT_LOAD_A, 4'd15, 4'd15, 32'sh7FFF_FFFF, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd16, TOL_MAX, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0},
      '{5'd31, 31'd0, ACT_START, 4'd0, 4'd0, 32'sd0, 1'b0, 32'sd0, 5'd0, 1'b0, 1'b0}
    };

    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; in_action = ACT_LOAD_A; in_row = '0; in_col = '0; in_value = '0;
    mismatches = 0; solves_seen = 0; records_seen = 0; items_sent = 0; cycles = 0;
    size_reg = 5'd16;
    tol_reg = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both stores completely, so that no solve ever reads an entry that
    // was never written. The matrix starts diagonally dominant.
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++)
        send_command(ACT_LOAD_A, 4'(i), 4'(j),
                     (i == j) ? 32'sh0020_0000 : $signed(32'($urandom_range(0, 32'h8000))), 1'b0);
      send_command(ACT_LOAD_B, 4'(i), 4'd0, $signed(32'($urandom_range(0, 32'h4_0000))), 1'b0);
    end

    // Directed table.
    foreach (directed_tab[k]) begin
      if (directed_tab[k].size != size_reg || directed_tab[k].tol != tol_reg)
        configure(directed_tab[k].size, directed_tab[k].tol);
      send_command(directed_tab[k].action, directed_tab[k].row, directed_tab[k].col,
                   directed_tab[k].value, !directed_tab[k].known);
      if (directed_tab[k].known) begin
        typed_rec = '{4'd0, directed_tab[k].k_solution, directed_tab[k].k_iterations,
                      directed_tab[k].k_converged, directed_tab[k].k_zero_pivot, 1'b1};
        pending_solutions.push_back(typed_rec);
      end
      command_gap();
    end

    // Random phases: each sets the registers, loads a burst (mostly a
    // diagonally dominant system with random content, partly noise over the
    // whole field ranges) and then starts a solve. Small sizes keep the
    // sweeps short; the full size turns up now and then.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 11);
      sz = (pick == 0) ? 5'd16 : ((pick == 1) ? 5'(8 + $urandom_range(0, 1) * 23) :
           ((pick == 2) ? 5'd0 : 5'($urandom_range(1, 4))));
      pick = $urandom_range(0, 4);
      tol = (pick == 0) ? 31'd0 : ((pick == 1) ? TOL_MAX :
            ((pick == 2) ? 31'($urandom) : 31'($urandom_range(1, 32'h400))));
      configure(sz, tol);
      n = (sz < 1) ? 1 : ((sz > DIM) ? DIM : int'(sz));
      burst = $urandom_range(2, 14);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_command(2'($urandom_range(0, 3) == 2 ? ACT_IGNORED : $urandom_range(0, 1)),
                       4'($urandom), 4'($urandom), $signed($urandom), 1'b0);
          if (in_action != ACT_IGNORED) random_count++;
        end else begin
          r = 4'($urandom_range(0, n - 1));
          c = 4'($urandom_range(0, n - 1));
          if ($urandom_range(0, 3) == 0) begin
            v = $signed(32'($urandom_range(0, 32'h8_0000))) - 32'sh4_0000;
            send_command(ACT_LOAD_B, r, c, v, 1'b0);
          end else begin
            if (r == c)
              v = $signed(32'($urandom_range(n * 32'h2_0000, n * 32'h4_0000)));
            else
              v = $signed(32'($urandom_range(0, 32'h1_0000))) - 32'sh8000;
            if (r == c && $urandom_range(0, 1)) v = -v;
            send_command(ACT_LOAD_A, r, c, v, 1'b0);
          end
          random_count++;
        end
        command_gap();
      end
      send_command(ACT_START, 4'($urandom), 4'($urandom), $signed($urandom), 1'b1);
      random_count++;
      command_gap();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("%0d command transactions, %0d solves, %0d solution records checked",
             items_sent, solves_seen, records_seen);
    if (mismatches == 0 && pending_solutions.size() == 0) begin
      $display("jacobi_linear_solver_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d records still expected", mismatches,
               pending_solutions.size());
      $display("jacobi_linear_solver_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
